FILE: rtl/hrp_pkg.sv
package hrp_pkg;

    localparam int unsigned KEY_LEN = 14;

    typedef enum logic [22:0] {
        PH_H        = 23'h000001,
        PH_T1       = 23'h000002,
        PH_T2       = 23'h000004,
        PH_P        = 23'h000008,
        PH_SLASH    = 23'h000010,
        PH_MAJ0     = 23'h000020,
        PH_MAJ      = 23'h000040,
        PH_MIN0     = 23'h000080,
        PH_MIN      = 23'h000100,
        PH_ST0      = 23'h000200,
        PH_ST1      = 23'h000400,
        PH_ST2      = 23'h000800,
        PH_REASON   = 23'h001000,
        PH_LF_STAT  = 23'h002000,
        PH_LINE     = 23'h004000,
        PH_NAME     = 23'h008000,
        PH_SPACE    = 23'h010000,
        PH_VALUE    = 23'h020000,
        PH_BODY0    = 23'h040000,
        PH_BODY     = 23'h080000,
        PH_LF_HDR   = 23'h100000,
        PH_LF_BLANK = 23'h200000,
        PH_LF_BODY  = 23'h400000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_NAME     = 3'd1,
        KIND_VALUE    = 3'd2,
        KIND_HDR_DONE = 3'd3,
        KIND_BODY     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        VAL_EMPTY = 2'd0,
        VAL_ZERO  = 2'd1,
        VAL_OTHER = 2'd2
    } val_match_t;

    typedef struct packed {
        phase_t     phase;
        logic [9:0] status_value;
        logic       status_complete;
        logic [3:0] name_pos;
        logic       name_alive;
        val_match_t value_pos;
        logic       len_found;
        logic       len_nonzero;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:           PH_H,
        status_value:    10'd0,
        status_complete: 1'b0,
        name_pos:        4'd0,
        name_alive:      1'b1,
        value_pos:       VAL_EMPTY,
        len_found:       1'b0,
        len_nonzero:     1'b0
    };

    typedef struct packed {
        logic       accepted;
        kind_t      item_kind;
        logic [7:0] out_byte;
        logic [9:0] status_code;
        logic       status_valid;
        logic       reply_done;
    } result_t;

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "C";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "L";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= 8'd31) || (c == 8'd127);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic s;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
            "=", "{", "}", " ", 8'h09: s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_sep(c);
    endfunction

endpackage

FILE: rtl/http_response_byte_parser.sv
// HTTP response byte parser: takes one response byte per clock unless stalled and returns
// one registered result per byte in the next cycle, one per cycle while the output does
// not stall, a rate set by the parse-state register, whose next value comes combinationally
// from the byte. The input is stalled only while a result is waiting and the output stalls.
module http_response_byte_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic [2:0] item_kind,
    output logic [7:0] out_byte,
    output logic [9:0] status_code,
    output logic       status_valid,
    output logic       reply_done
);

    hrp_pkg::state_t  state_reg;
    hrp_pkg::state_t  state_next;
    hrp_pkg::result_t step_res;
    hrp_pkg::result_t res_out;
    logic             busy;
    logic             load;

    assign in_stall = busy;
    assign load     = in_valid && !busy;

    hrp_step u_step (
        .cur (state_reg),
        .c   (in_byte),
        .nxt (state_next),
        .res (step_res)
    );

    // advance parse state once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hrp_pkg::STATE_RESET;
        else if (load)
            state_reg <= state_next;
    end

    hrp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res_in    (step_res),
        .out_stall (out_stall),
        .busy      (busy),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign accepted     = res_out.accepted;
    assign item_kind    = res_out.item_kind;
    assign out_byte     = res_out.out_byte;
    assign status_code  = res_out.status_code;
    assign status_valid = res_out.status_valid;
    assign reply_done   = res_out.reply_done;

endmodule

FILE: rtl/hrp_step.sv
module hrp_step (
    input  hrp_pkg::state_t  cur,
    input  logic [7:0]       c,
    output hrp_pkg::state_t  nxt,
    output hrp_pkg::result_t res
);

    hrp_pkg::state_t upd;
    hrp_pkg::kind_t  kind;
    logic            ok;
    logic            done;
    logic            digit;
    logic [9:0]      dval;
    logic            key_hit;
    logic            key_hit_first;
    logic [3:0]      match_pos;
    logic            match_alive;

    assign digit = (c >= "0") && (c <= "9");
    assign dval  = {6'd0, c[3:0]};

    assign key_hit = cur.name_alive && (cur.name_pos < 4'(hrp_pkg::KEY_LEN))
                     && (c == hrp_pkg::key_char(cur.name_pos));
    assign key_hit_first = (c == hrp_pkg::key_char(4'd0));

    always_comb
    begin
        upd         = cur;
        kind        = hrp_pkg::KIND_NONE;
        ok          = 1'b1;
        done        = 1'b0;
        match_pos   = cur.name_pos;
        match_alive = cur.name_alive;
        case (cur.phase)
            hrp_pkg::PH_H:
            begin
                if (c == "H")
                    upd.phase = hrp_pkg::PH_T1;
                else if (c != 8'd10 && c != 8'd13)
                    ok = 1'b0;
            end
            hrp_pkg::PH_T1:
                if (c == "T") upd.phase = hrp_pkg::PH_T2; else ok = 1'b0;
            hrp_pkg::PH_T2:
                if (c == "T") upd.phase = hrp_pkg::PH_P; else ok = 1'b0;
            hrp_pkg::PH_P:
                if (c == "P") upd.phase = hrp_pkg::PH_SLASH; else ok = 1'b0;
            hrp_pkg::PH_SLASH:
                if (c == "/") upd.phase = hrp_pkg::PH_MAJ0; else ok = 1'b0;
            hrp_pkg::PH_MAJ0:
                if (digit) upd.phase = hrp_pkg::PH_MAJ; else ok = 1'b0;
            hrp_pkg::PH_MAJ:
            begin
                if (c == ".")
                    upd.phase = hrp_pkg::PH_MIN0;
                else if (!digit)
                    ok = 1'b0;
            end
            hrp_pkg::PH_MIN0:
                if (digit) upd.phase = hrp_pkg::PH_MIN; else ok = 1'b0;
            hrp_pkg::PH_MIN:
            begin
                if (c == " ")
                    upd.phase = hrp_pkg::PH_ST0;
                else if (!digit)
                    ok = 1'b0;
            end
            hrp_pkg::PH_ST0:
            begin
                if (digit)
                begin
                    upd.status_value = dval * 10'd100;
                    upd.phase        = hrp_pkg::PH_ST1;
                end
                else
                    ok = 1'b0;
            end
            hrp_pkg::PH_ST1:
            begin
                if (digit)
                begin
                    upd.status_value = cur.status_value + dval * 10'd10;
                    upd.phase        = hrp_pkg::PH_ST2;
                end
                else
                    ok = 1'b0;
            end
            hrp_pkg::PH_ST2:
            begin
                if (digit)
                begin
                    upd.status_value    = cur.status_value + dval;
                    upd.status_complete = 1'b1;
                    upd.phase           = hrp_pkg::PH_REASON;
                end
                else
                    ok = 1'b0;
            end
            hrp_pkg::PH_REASON:
            begin
                if (digit)
                    ok = 1'b0;
                else if (c == 8'd13)
                    upd.phase = hrp_pkg::PH_LF_STAT;
            end
            hrp_pkg::PH_LF_STAT:
                if (c == 8'd10) upd.phase = hrp_pkg::PH_LINE; else ok = 1'b0;
            hrp_pkg::PH_LINE:
            begin
                if (c == 8'd13)
                    upd.phase = hrp_pkg::PH_LF_BLANK;
                else if (hrp_pkg::is_token(c))
                begin
                    upd.value_pos  = hrp_pkg::VAL_EMPTY;
                    upd.name_pos   = key_hit_first ? 4'd1 : 4'd0;
                    upd.name_alive = key_hit_first;
                    kind           = hrp_pkg::KIND_NAME;
                    upd.phase      = hrp_pkg::PH_NAME;
                end
                else
                    ok = 1'b0;
            end
            hrp_pkg::PH_NAME:
            begin
                if (c == ":")
                    upd.phase = hrp_pkg::PH_SPACE;
                else if (hrp_pkg::is_token(c))
                begin
                    if (key_hit)
                        match_pos = cur.name_pos + 4'd1;
                    else
                        match_alive = 1'b0;
                    upd.name_pos   = match_pos;
                    upd.name_alive = match_alive;
                    kind           = hrp_pkg::KIND_NAME;
                end
                else
                    ok = 1'b0;
            end
            hrp_pkg::PH_SPACE:
                if (c == " ") upd.phase = hrp_pkg::PH_VALUE; else ok = 1'b0;
            hrp_pkg::PH_VALUE:
            begin
                if (c == 8'd13)
                begin
                    if (cur.name_alive && cur.name_pos == 4'(hrp_pkg::KEY_LEN)
                        && !cur.len_found)
                    begin
                        upd.len_found   = 1'b1;
                        upd.len_nonzero = (cur.value_pos != hrp_pkg::VAL_ZERO);
                    end
                    kind      = hrp_pkg::KIND_HDR_DONE;
                    upd.phase = hrp_pkg::PH_LF_HDR;
                end
                else if (hrp_pkg::is_ctl(c))
                    ok = 1'b0;
                else
                begin
                    upd.value_pos = (cur.value_pos == hrp_pkg::VAL_EMPTY && c == "0")
                                    ? hrp_pkg::VAL_ZERO : hrp_pkg::VAL_OTHER;
                    kind = hrp_pkg::KIND_VALUE;
                end
            end
            hrp_pkg::PH_BODY0:
            begin
                if (c == 8'd13)
                    upd.phase = hrp_pkg::PH_LF_BLANK;
                else
                begin
                    kind      = hrp_pkg::KIND_BODY;
                    upd.phase = hrp_pkg::PH_BODY;
                end
            end
            hrp_pkg::PH_BODY:
            begin
                if (c == 8'd13)
                    upd.phase = hrp_pkg::PH_LF_BODY;
                else
                    kind = hrp_pkg::KIND_BODY;
            end
            hrp_pkg::PH_LF_HDR:
                if (c == 8'd10) upd.phase = hrp_pkg::PH_LINE; else ok = 1'b0;
            hrp_pkg::PH_LF_BLANK:
            begin
                if (c == 8'd10)
                begin
                    if (cur.len_found && cur.len_nonzero)
                        upd.phase = hrp_pkg::PH_BODY0;
                    else
                        done = 1'b1;
                end
                else
                    ok = 1'b0;
            end
            hrp_pkg::PH_LF_BODY:
                if (c == 8'd10) done = 1'b1; else ok = 1'b0;
            default:
                ok = 1'b0;
        endcase
    end

    always_comb
    begin
        res.accepted     = ok;
        res.item_kind    = ok ? kind : hrp_pkg::KIND_NONE;
        res.out_byte     = (ok && (kind == hrp_pkg::KIND_NAME || kind == hrp_pkg::KIND_VALUE
                           || kind == hrp_pkg::KIND_BODY)) ? c : 8'd0;
        res.status_code  = upd.status_value;
        res.status_valid = upd.status_complete;
        res.reply_done   = done;
        nxt              = (!ok || done) ? hrp_pkg::STATE_RESET : upd;
    end

endmodule

FILE: rtl/hrp_out_stage.sv
module hrp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  hrp_pkg::result_t res_in,
    input  logic             out_stall,
    output logic             busy,
    output logic             out_valid,
    output hrp_pkg::result_t res_out
);

    logic             valid_reg;
    hrp_pkg::result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

    assign busy      = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

FILE: sim/http_response_byte_parser_tb.sv
module http_response_byte_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    class reply_scoreboard;

        localparam logic [111:0] LENGTH_KEY = "Content-Length";
        localparam int           KEY_CHARS  = 14;

        hrp_pkg::result_t    pending_results[$];
        int                  mismatches;

        hrp_pkg::phase_t     phase;
        logic [9:0]          status_val;
        logic                status_done;
        logic [3:0]          key_pos;
        logic                key_alive;
        hrp_pkg::val_match_t val_state;
        logic                len_seen;
        logic                len_nonzero;

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase       = hrp_pkg::PH_H;
            status_val  = '0;
            status_done = 1'b0;
            key_pos     = '0;
            key_alive   = 1'b1;
            val_state   = hrp_pkg::VAL_EMPTY;
            len_seen    = 1'b0;
            len_nonzero = 1'b0;
        endfunction

        static function bit is_digit_byte(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function bit is_ctrl(logic [7:0] c);
            return c < 8'd32 || c == 8'd127;
        endfunction

        static function bit is_name_byte(logic [7:0] c);
            bit    sep;
            string seps;
            sep  = 1'b0;
            seps = "()<>@,;:\\\"/[]?={} ";
            foreach (seps[i])
                if (c == seps[i])
                    sep = 1'b1;
            if (c == 8'h09)
                sep = 1'b1;
            return c < 8'd128 && !is_ctrl(c) && !sep;
        endfunction

        function void note_result(hrp_pkg::result_t r);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void advance_key(logic [7:0] c);
            if (key_alive && key_pos < KEY_CHARS
                && c == LENGTH_KEY[8 * (KEY_CHARS - 1 - int'(key_pos)) +: 8])
                key_pos = key_pos + 4'd1;
            else
                key_alive = 1'b0;
        endfunction

        function void take_byte(logic [7:0] c);
            hrp_pkg::result_t r;
            bit               ok;
            bit               done;
            hrp_pkg::kind_t   kind;
            hrp_pkg::phase_t  nxt;
            ok   = 1'b1;
            done = 1'b0;
            kind = hrp_pkg::KIND_NONE;
            nxt  = phase;
            case (phase)
                hrp_pkg::PH_H:
                    if (c == "H")
                        nxt = hrp_pkg::PH_T1;
                    else if (c != 8'h0a && c != 8'h0d)
                        ok = 1'b0;
                hrp_pkg::PH_T1:
                    if (c == "T") nxt = hrp_pkg::PH_T2; else ok = 1'b0;
                hrp_pkg::PH_T2:
                    if (c == "T") nxt = hrp_pkg::PH_P; else ok = 1'b0;
                hrp_pkg::PH_P:
                    if (c == "P") nxt = hrp_pkg::PH_SLASH; else ok = 1'b0;
                hrp_pkg::PH_SLASH:
                    if (c == "/") nxt = hrp_pkg::PH_MAJ0; else ok = 1'b0;
                hrp_pkg::PH_MAJ0:
                    if (is_digit_byte(c)) nxt = hrp_pkg::PH_MAJ; else ok = 1'b0;
                hrp_pkg::PH_MAJ:
                    if (c == ".")
                        nxt = hrp_pkg::PH_MIN0;
                    else if (!is_digit_byte(c))
                        ok = 1'b0;
                hrp_pkg::PH_MIN0:
                    if (is_digit_byte(c)) nxt = hrp_pkg::PH_MIN; else ok = 1'b0;
                hrp_pkg::PH_MIN:
                    if (c == " ")
                        nxt = hrp_pkg::PH_ST0;
                    else if (!is_digit_byte(c))
                        ok = 1'b0;
                hrp_pkg::PH_ST0:
                    if (is_digit_byte(c))
                    begin
                        status_val = 10'(100 * (int'(c) - 48));
                        nxt = hrp_pkg::PH_ST1;
                    end
                    else
                        ok = 1'b0;
                hrp_pkg::PH_ST1:
                    if (is_digit_byte(c))
                    begin
                        status_val = 10'(int'(status_val) + 10 * (int'(c) - 48));
                        nxt = hrp_pkg::PH_ST2;
                    end
                    else
                        ok = 1'b0;
                hrp_pkg::PH_ST2:
                    if (is_digit_byte(c))
                    begin
                        status_val  = 10'(int'(status_val) + int'(c) - 48);
                        status_done = 1'b1;
                        nxt = hrp_pkg::PH_REASON;
                    end
                    else
                        ok = 1'b0;
                hrp_pkg::PH_REASON:
                    if (is_digit_byte(c))
                        ok = 1'b0;
                    else if (c == 8'h0d)
                        nxt = hrp_pkg::PH_LF_STAT;
                hrp_pkg::PH_LF_STAT:
                    if (c == 8'h0a) nxt = hrp_pkg::PH_LINE; else ok = 1'b0;
                hrp_pkg::PH_LINE:
                    if (c == 8'h0d)
                        nxt = hrp_pkg::PH_LF_BLANK;
                    else if (is_name_byte(c))
                    begin
                        key_pos   = '0;
                        key_alive = 1'b1;
                        val_state = hrp_pkg::VAL_EMPTY;
                        advance_key(c);
                        kind = hrp_pkg::KIND_NAME;
                        nxt  = hrp_pkg::PH_NAME;
                    end
                    else
                        ok = 1'b0;
                hrp_pkg::PH_NAME:
                    if (c == ":")
                        nxt = hrp_pkg::PH_SPACE;
                    else if (is_name_byte(c))
                    begin
                        advance_key(c);
                        kind = hrp_pkg::KIND_NAME;
                    end
                    else
                        ok = 1'b0;
                hrp_pkg::PH_SPACE:
                    if (c == " ") nxt = hrp_pkg::PH_VALUE; else ok = 1'b0;
                hrp_pkg::PH_VALUE:
                    if (c == 8'h0d)
                    begin
                        if (key_alive && key_pos == KEY_CHARS && !len_seen)
                        begin
                            len_seen    = 1'b1;
                            len_nonzero = val_state != hrp_pkg::VAL_ZERO;
                        end
                        kind = hrp_pkg::KIND_HDR_DONE;
                        nxt  = hrp_pkg::PH_LF_HDR;
                    end
                    else if (is_ctrl(c))
                        ok = 1'b0;
                    else
                    begin
                        val_state = (val_state == hrp_pkg::VAL_EMPTY && c == "0")
                                    ? hrp_pkg::VAL_ZERO : hrp_pkg::VAL_OTHER;
                        kind = hrp_pkg::KIND_VALUE;
                    end
                hrp_pkg::PH_BODY0:
                    if (c == 8'h0d)
                        nxt = hrp_pkg::PH_LF_BLANK;
                    else
                    begin
                        kind = hrp_pkg::KIND_BODY;
                        nxt  = hrp_pkg::PH_BODY;
                    end
                hrp_pkg::PH_BODY:
                    if (c == 8'h0d)
                        nxt = hrp_pkg::PH_LF_BODY;
                    else
                        kind = hrp_pkg::KIND_BODY;
                hrp_pkg::PH_LF_HDR:
                    if (c == 8'h0a) nxt = hrp_pkg::PH_LINE; else ok = 1'b0;
                hrp_pkg::PH_LF_BLANK:
                    if (c == 8'h0a)
                    begin
                        if (len_seen && len_nonzero)
                            nxt = hrp_pkg::PH_BODY0;
                        else
                            done = 1'b1;
                    end
                    else
                        ok = 1'b0;
                hrp_pkg::PH_LF_BODY:
                    if (c == 8'h0a) done = 1'b1; else ok = 1'b0;
                default: ok = 1'b0;
            endcase
            if (!ok)
                kind = hrp_pkg::KIND_NONE;
            r.accepted     = ok;
            r.item_kind    = kind;
            r.out_byte     = (kind == hrp_pkg::KIND_NAME || kind == hrp_pkg::KIND_VALUE
                              || kind == hrp_pkg::KIND_BODY) ? c : 8'd0;
            r.status_code  = status_val;
            r.status_valid = status_done;
            r.reply_done   = done;
            note_result(r);
            if (!ok || done)
                clear_state();
            else
                phase = nxt;
        endfunction

        function void check_beat(logic a, logic [2:0] k, logic [7:0] b, logic [9:0] s,
                                 logic sv, logic d);
            hrp_pkg::result_t e;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected", $realtime);
                return;
            end
            e = pending_results.pop_front();
            if (a !== e.accepted || k !== e.item_kind || b !== e.out_byte
                || s !== e.status_code || sv !== e.status_valid || d !== e.reply_done)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $write("%0t: mismatch exp acc=%0b kind=%0d byte=%h st=%0d sv=%0b done=%0b",
                           $realtime, e.accepted, e.item_kind, e.out_byte, e.status_code,
                           e.status_valid, e.reply_done);
                    $display(" / act acc=%0b kind=%0d byte=%h st=%0d sv=%0b done=%0b",
                             a, k, b, s, sv, d);
                end
            end
        endfunction

    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic       accepted;
    logic [2:0] item_kind;
    logic [7:0] out_byte;
    logic [9:0] status_code;
    logic       status_valid;
    logic       reply_done;

    reply_scoreboard sb;
    logic [7:0]      stim_bytes[$];
    bit              rx_hold_req;
    bit              rx_quiet;
    bit              tx_quiet;

    http_response_byte_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .item_kind    (item_kind),
        .out_byte     (out_byte),
        .status_code  (status_code),
        .status_valid (status_valid),
        .reply_done   (reply_done)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void append_byte(logic [7:0] b);
        stim_bytes.insert(stim_bytes.size(), b);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    function automatic void push_digits(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++)
            append_byte(8'(48 + $urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] rand_name_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (!reply_scoreboard::is_name_byte(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_value_byte();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic void build_reply(int mangle);
        int start;
        int line_start;
        int n;
        int pick;
        bit len_known;
        bit body_due;
        bit is_key;
        start     = stim_bytes.size();
        len_known = 1'b0;
        body_due  = 1'b0;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                append_byte($urandom_range(0, 1) ? 8'h0d : 8'h0a);
        push_text("HTTP/");
        push_digits(1, 2);
        push_text(".");
        push_digits(1, 2);
        push_text(" ");
        push_digits(3, 3);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
        begin
            logic [7:0] c;
            do
                c = 8'($urandom_range(0, 255));
            while (reply_scoreboard::is_digit_byte(c) || c == 8'h0d);
            append_byte(c);
        end
        push_text("\r\n");
        line_start = stim_bytes.size();
        repeat ($urandom_range(0, 3))
        begin
            is_key = 1'b0;
            pick = $urandom_range(0, 5);
            case (pick)
                0, 1:
                begin
                    push_text("Content-Length");
                    is_key = 1'b1;
                end
                2: push_text("content-length");
                3: push_text("Content-Len");
                4: push_text("Content-Lengthy");
                default:
                    repeat ($urandom_range(1, 5))
                        append_byte(rand_name_byte());
            endcase
            push_text(": ");
            pick = $urandom_range(0, 4);
            case (pick)
                0: ;
                1: push_text("0");
                2: push_text("00");
                3: push_digits(1, 3);
                default:
                    repeat ($urandom_range(1, 5))
                        append_byte(rand_value_byte());
            endcase
            if (is_key && !len_known)
            begin
                len_known = 1'b1;
                body_due  = pick != 1;
            end
            push_text("\r\n");
        end
        push_text("\r\n");
        if (body_due)
        begin
            if ($urandom_range(0, 4) == 0)
                push_text("\r\n");
            repeat ($urandom_range(1, 8))
            begin
                logic [7:0] c;
                do
                    c = 8'($urandom_range(0, 255));
                while (c == 8'h0d);
                append_byte(c);
            end
            push_text("\r\n");
        end
        case (mangle)
            1: stim_bytes[$urandom_range(start, stim_bytes.size() - 1)] =
                   8'($urandom_range(0, 255));
            2: stim_bytes.insert($urandom_range(start, stim_bytes.size() - 1),
                                 8'($urandom_range(0, 255)));
            3: stim_bytes.insert(line_start, $urandom_range(0, 1) ? 8'h20 : 8'h09);
            default: ;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_byte(b);
    endtask

    initial
    begin
        int stall_left;
        int run_left;
        int hold_left;
        int cycle;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        cycle      = 0;
        out_stall  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_beat(accepted, item_kind, out_byte, status_code, status_valid,
                              reply_done);
            cycle++;
            if (cycle % 80 == 0)
                rx_quiet = $urandom_range(0, 2) == 0;
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    run_left   = $urandom_range(0, 12);
                    stall_left = rx_quiet ? 0 : idle_len();
                end
            end
        end
    end

    initial
    begin
        int directed_len;
        int hold_at;
        int drain_at;
        int gap;
        int pick;
        sb          = new();
        rx_hold_req = 1'b0;
        rx_quiet    = 1'b0;
        tx_quiet    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'd0;

        push_text("\r\nHTTP/1.0 999 \r\n\r\n");
        append_byte(8'hff);
        push_text("H");
        append_byte(8'h00);
        directed_len = stim_bytes.size();
        while (stim_bytes.size() < directed_len + RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                build_reply(0);
            else if (pick < 85)
                build_reply($urandom_range(1, 3));
            else
            begin
                if ($urandom_range(0, 1))
                    push_text("H");
                repeat ($urandom_range(1, 6))
                    append_byte(8'($urandom_range(0, 255)));
            end
        end
        hold_at  = directed_len + 60;
        drain_at = directed_len + 220;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_bytes[i])
        begin
            if (i == hold_at)
                rx_hold_req = 1'b1;
            if (i == drain_at)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending_results.size() != 0);
            end
            if (i % 50 == 0)
                tx_quiet = $urandom_range(0, 2) == 0;
            gap = tx_quiet ? 0 : idle_len();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            send_byte(stim_bytes[i]);
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
        repeat (5) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("http_response_byte_parser verification clean");
        else
            $display("http_response_byte_parser verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("http_response_byte_parser verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/hrp_pkg.sv
rtl/hrp_step.sv
rtl/hrp_out_stage.sv
rtl/http_response_byte_parser.sv
sim/http_response_byte_parser_tb.sv
